// ===== design/bbrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbrt_pkg: shared types and constants of the buffer reference count table
// Slot geometry, operation and status codes, transfer payloads and the
// count table ports.
// ----------------------------------------------------------------------------
package bbrt_pkg;

    localparam int NUM_SLOTS    = 32;
    localparam int NUM_BUCKETS  = 13;
    localparam int SLOT_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int IDX_W        = $clog2(NUM_SLOTS + NUM_BUCKETS);
    localparam int SLOT_FIELD_W = 5;
    localparam int DEV_W        = 8;
    localparam int BLK_W        = 32;
    localparam int TAG_W        = DEV_W + BLK_W;
    localparam int CNT_W        = 8;

    typedef enum logic [1:0] {
        OP_GET     = 2'd0,
        OP_RELEASE = 2'd1,
        OP_PIN     = 2'd2,
        OP_UNPIN   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NOBUF = 2'd1,
        ST_UNDER = 2'd2,
        ST_OVER  = 2'd3
    } t_status;

    typedef struct packed {
        t_opcode                 opcode;
        logic [DEV_W-1:0]        device;
        logic [BLK_W-1:0]        block_number;
        logic [SLOT_FIELD_W-1:0] slot_index;
    } t_in_item;

    typedef struct packed {
        logic [SLOT_FIELD_W-1:0] slot;
        logic                    hit;
        logic                    needs_read;
        t_status                 status;
        logic [CNT_W-1:0]        count_after;
    } t_out_item;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [CNT_W-1:0]  count;
        logic              listed;
    } t_cnt_wr;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             listed;
    } t_cnt_rd;

endpackage

// ===== design/bbrt_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbrt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle. Contents are not reset.
// ----------------------------------------------------------------------------
module bbrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/bbrt_cnt_tbl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbrt_cnt_tbl: reference counts and listed flags of all slots
// Flip-flop table cleared by reset, with one read port and one write port.
// ----------------------------------------------------------------------------
module bbrt_cnt_tbl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bbrt_pkg::SLOT_W-1:0]   i_rd_addr,
    output bbrt_pkg::t_cnt_rd             o_rd,
    input  bbrt_pkg::t_cnt_wr             i_wr
);
    import bbrt_pkg::*;

    logic [CNT_W-1:0]     r_count [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_listed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_count[k] <= '0;
            end
            r_listed <= '0;
        end else if (i_wr.en) begin
            r_count[i_wr.addr]  <= i_wr.count;
            r_listed[i_wr.addr] <= i_wr.listed;
        end
    end

    assign o_rd.count  = r_count[i_rd_addr];
    assign o_rd.listed = r_listed[i_rd_addr];

endmodule

// ===== design/bbrt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbrt_ctrl: sequencer of the buffer reference count table
// For a get, scans the tag RAM for a hit, then the counts in bucket-stride order
// for a free slot; updates at most one count per operation through a shared adder.
// ----------------------------------------------------------------------------
module bbrt_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  bbrt_pkg::t_in_item          i_in_data,
    output logic                        o_in_stall,
    input  logic                        i_res_ready,
    output logic                        o_res_valid,
    output bbrt_pkg::t_out_item         o_res,
    output logic                        o_tag_wr_en,
    output logic [bbrt_pkg::SLOT_W-1:0] o_tag_wr_addr,
    output logic [bbrt_pkg::TAG_W-1:0]  o_tag_wr_data,
    output logic [bbrt_pkg::SLOT_W-1:0] o_tag_rd_addr,
    input  logic [bbrt_pkg::TAG_W-1:0]  i_tag_rd_data,
    output logic [bbrt_pkg::SLOT_W-1:0] o_cnt_rd_addr,
    input  bbrt_pkg::t_cnt_rd           i_cnt_rd,
    output bbrt_pkg::t_cnt_wr           o_cnt_wr
);
    import bbrt_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_HSCAN = 7'b0000010,
        S_FSCAN = 7'b0000100,
        S_HIT   = 7'b0001000,
        S_ALLOC = 7'b0010000,
        S_NOBUF = 7'b0100000,
        S_UPD   = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    t_in_item          r_req, n_req;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [IDX_W-1:0]  r_bkt, n_bkt;
    logic              r_cmp_vld, n_cmp_vld;
    logic [SLOT_W-1:0] r_cmp_idx, n_cmp_idx;
    logic [SLOT_W-1:0] r_slot, n_slot;

    logic              tag_match;
    logic              cnt_dec;
    logic [CNT_W-1:0]  cnt_sum;
    logic              cnt_max;
    logic              cnt_zero;
    logic [IDX_W-1:0]  next_pos;
    logic [IDX_W-1:0]  next_bkt;
    logic              slot_oor;

    assign tag_match = (i_tag_rd_data == {r_req.device, r_req.block_number});
    assign cnt_dec   = (r_state == S_UPD) &&
                       (r_req.opcode == OP_RELEASE || r_req.opcode == OP_UNPIN);
    assign cnt_sum   = i_cnt_rd.count + (cnt_dec ? {CNT_W{1'b1}} : CNT_W'(1));
    assign cnt_max   = (i_cnt_rd.count == {CNT_W{1'b1}});
    assign cnt_zero  = (i_cnt_rd.count == '0);
    assign next_pos  = r_idx + IDX_W'(NUM_BUCKETS);
    assign next_bkt  = r_bkt + IDX_W'(1);
    assign slot_oor  = (32'(r_req.slot_index) >= 32'(NUM_SLOTS));

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_tag_rd_addr = r_idx[SLOT_W-1:0];
    assign o_tag_wr_addr = r_slot;
    assign o_tag_wr_data = {r_req.device, r_req.block_number};

    always_comb begin
        n_state       = r_state;
        n_req         = r_req;
        n_idx         = r_idx;
        n_bkt         = r_bkt;
        n_cmp_vld     = 1'b0;
        n_cmp_idx     = r_cmp_idx;
        n_slot        = r_slot;
        o_res_valid   = 1'b0;
        o_res         = '0;
        o_tag_wr_en   = 1'b0;
        o_cnt_rd_addr = r_slot;
        o_cnt_wr      = '0;
        o_cnt_wr.addr = r_slot;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_req  = i_in_data;
                    n_idx  = '0;
                    n_slot = SLOT_W'(i_in_data.slot_index);
                    if (i_in_data.opcode == OP_GET) begin
                        n_state = S_HSCAN;
                    end else begin
                        n_state = S_UPD;
                    end
                end
            end
            S_HSCAN: begin
                o_cnt_rd_addr = r_cmp_idx;
                if (r_idx < IDX_W'(NUM_SLOTS)) begin
                    n_idx     = r_idx + IDX_W'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_idx[SLOT_W-1:0];
                end
                if (r_cmp_vld && i_cnt_rd.listed && tag_match) begin
                    n_slot  = r_cmp_idx;
                    n_state = S_HIT;
                end else if (r_cmp_vld && r_cmp_idx == SLOT_W'(NUM_SLOTS - 1)) begin
                    n_idx   = '0;
                    n_bkt   = '0;
                    n_state = S_FSCAN;
                end
            end
            S_FSCAN: begin
                o_cnt_rd_addr = r_idx[SLOT_W-1:0];
                if (cnt_zero) begin
                    n_slot  = r_idx[SLOT_W-1:0];
                    n_state = S_ALLOC;
                end else if (next_pos < IDX_W'(NUM_SLOTS)) begin
                    n_idx = next_pos;
                end else if (next_bkt >= IDX_W'(NUM_BUCKETS) ||
                             next_bkt >= IDX_W'(NUM_SLOTS)) begin
                    n_state = S_NOBUF;
                end else begin
                    n_bkt = next_bkt;
                    n_idx = next_bkt;
                end
            end
            S_HIT: begin
                o_res_valid      = 1'b1;
                o_res.slot       = SLOT_FIELD_W'(r_slot);
                o_res.hit        = 1'b1;
                o_res.status     = cnt_max ? ST_OVER : ST_OK;
                o_res.count_after = cnt_max ? i_cnt_rd.count : cnt_sum;
                o_cnt_wr.count   = cnt_sum;
                o_cnt_wr.listed  = 1'b1;
                if (i_res_ready) begin
                    o_cnt_wr.en = !cnt_max;
                    n_state     = S_IDLE;
                end
            end
            S_ALLOC: begin
                o_res_valid       = 1'b1;
                o_res.slot        = SLOT_FIELD_W'(r_slot);
                o_res.needs_read  = 1'b1;
                o_res.status      = ST_OK;
                o_res.count_after = CNT_W'(1);
                o_cnt_wr.count    = CNT_W'(1);
                o_cnt_wr.listed   = 1'b1;
                if (i_res_ready) begin
                    o_cnt_wr.en = 1'b1;
                    o_tag_wr_en = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_NOBUF: begin
                o_res_valid  = 1'b1;
                o_res.status = ST_NOBUF;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_UPD: begin
                o_res_valid     = 1'b1;
                o_res.slot      = r_req.slot_index;
                o_cnt_wr.count  = cnt_sum;
                o_cnt_wr.listed = i_cnt_rd.listed;
                if (slot_oor) begin
                    o_res.status = ST_NOBUF;
                end else if (!cnt_dec) begin
                    o_res.status      = cnt_max ? ST_OVER : ST_OK;
                    o_res.count_after = cnt_max ? i_cnt_rd.count : cnt_sum;
                    o_cnt_wr.en       = i_res_ready && !cnt_max;
                end else if (cnt_zero) begin
                    o_res.status = ST_UNDER;
                end else begin
                    o_res.status      = ST_OK;
                    o_res.count_after = cnt_sum;
                    if (r_req.opcode == OP_RELEASE && cnt_sum == '0) begin
                        o_cnt_wr.listed = 1'b0;
                    end
                    o_cnt_wr.en = i_res_ready;
                end
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cmp_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= n_cmp_vld;
        end
        r_req     <= n_req;
        r_idx     <= n_idx;
        r_bkt     <= n_bkt;
        r_cmp_idx <= n_cmp_idx;
        r_slot    <= n_slot;
    end

endmodule

// ===== design/block_buffer_refcount_table_top.sv =====
`timescale 1ns / 1ps
// Release, pin and unpin: the block enters S_UPD, and its result is then registered.
// Get with a hit on slot k: the tag RAM scan stops at slot k and S_HIT gives the result.
// Get with a miss: the one-slot-per-cycle tag RAM scan over all slots is followed by
// the one-slot-per-cycle free-count scan, which ends in S_ALLOC or S_NOBUF.
// One item is in work at a time; the next is taken once the result is registered.
// Reset is synchronous: counts and listed flags clear at once, the tag RAM is not.
// ----------------------------------------------------------------------------
// block_buffer_refcount_table_top: buffer reference count tag table
// Looks up, allocates, pins and releases buffer slots by device and block.
// ----------------------------------------------------------------------------
module block_buffer_refcount_table_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  bbrt_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output bbrt_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);
    import bbrt_pkg::*;

    logic              res_valid;
    logic              res_ready;
    t_out_item         res;
    logic              tag_wr_en;
    logic [SLOT_W-1:0] tag_wr_addr;
    logic [TAG_W-1:0]  tag_wr_data;
    logic [SLOT_W-1:0] tag_rd_addr;
    logic [TAG_W-1:0]  tag_rd_data;
    logic [SLOT_W-1:0] cnt_rd_addr;
    t_cnt_rd           cnt_rd;
    t_cnt_wr           cnt_wr;

    logic              r_out_vld;
    t_out_item         r_out;

    assign res_ready = !r_out_vld || !i_out_stall;

    bbrt_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_data     (i_in_data),
        .o_in_stall    (o_in_stall),
        .i_res_ready   (res_ready),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .o_tag_wr_en   (tag_wr_en),
        .o_tag_wr_addr (tag_wr_addr),
        .o_tag_wr_data (tag_wr_data),
        .o_tag_rd_addr (tag_rd_addr),
        .i_tag_rd_data (tag_rd_data),
        .o_cnt_rd_addr (cnt_rd_addr),
        .i_cnt_rd      (cnt_rd),
        .o_cnt_wr      (cnt_wr)
    );

    bbrt_ram #(
        .WIDTH (TAG_W),
        .DEPTH (NUM_SLOTS)
    ) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tag_wr_en),
        .i_wr_addr (tag_wr_addr),
        .i_wr_data (tag_wr_data),
        .i_rd_addr (tag_rd_addr),
        .o_rd_data (tag_rd_data)
    );

    bbrt_cnt_tbl u_cnt_tbl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (cnt_rd_addr),
        .o_rd      (cnt_rd),
        .i_wr      (cnt_wr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// ===== design/bbrt_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbrt_chk: port checker of the buffer reference count table
// Watches the transfers on both channels and the result codes.
// ----------------------------------------------------------------------------
module bbrt_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input bbrt_pkg::t_out_item o_out_data,
    input logic                i_out_stall
);
    import bbrt_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("Stalled result was dropped.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("Stalled result changed.");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("Block took no time over an accepted transfer.");

    a_hit_or_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.hit && o_out_data.needs_read))
        else $error("Result reports both a hit and a fresh allocation.");

    a_fresh_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.needs_read |->
            o_out_data.status == ST_OK && o_out_data.count_after == CNT_W'(1))
        else $error("Freshly allocated slot has a wrong count or status.");

endmodule

bind block_buffer_refcount_table_top bbrt_chk u_bbrt_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);
